// File: hw/rtl/mab_pkg.sv
// Shared constants and types for the moving average bank.
// No dependencies; imported by every module of the block.
package mab_pkg;

    localparam int HISTORY_DEPTH = 256;
    localparam int SAMPLE_BITS   = 24;

    localparam int DEPTH_BITS = $clog2(HISTORY_DEPTH);
    localparam int COUNT_BITS = DEPTH_BITS + 1;
    localparam int DIV_BITS   = $clog2(HISTORY_DEPTH * (HISTORY_DEPTH + 1) / 2 + 1);
    localparam int ACC_BITS   = SAMPLE_BITS + DIV_BITS;
    localparam int STEP_BITS  = $clog2(SAMPLE_BITS + 1);

    localparam int S_TDATA_BITS = ((SAMPLE_BITS + COUNT_BITS + 7) / 8) * 8;
    localparam int M_TDATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;

    localparam logic       OP_PUSH  = 1'b0;
    localparam logic       OP_QUERY = 1'b1;

    localparam logic [1:0] MODE_MEAN   = 2'd0;
    localparam logic [1:0] MODE_NEWEST = 2'd1;
    localparam logic [1:0] MODE_OLDEST = 2'd2;

    typedef struct packed {
        logic                   wr_en;
        logic [DEPTH_BITS-1:0]  wr_addr;
        logic [SAMPLE_BITS-1:0] wr_data;
        logic                   rd_en;
        logic [DEPTH_BITS-1:0]  rd_addr;
    } hist_req_t;

endpackage

// File: hw/rtl/mab_history.sv
// Sample history memory: one write port, one registered read port.
// Depends on mab_pkg for depth, sample width and the request struct.
module mab_history (
    input  logic                            clk,
    input  mab_pkg::hist_req_t              req,
    output logic [mab_pkg::SAMPLE_BITS-1:0] rd_data
);
    import mab_pkg::*;

    logic [SAMPLE_BITS-1:0] mem [HISTORY_DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data <= mem[req.rd_addr];
        end
    end

endmodule

// File: hw/rtl/mab_divider.sv
// Restoring divider, one quotient bit per cycle, for the weighted sum.
// Depends on mab_pkg; the quotient is known to fit SAMPLE_BITS.
module mab_divider (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [mab_pkg::ACC_BITS-1:0]    dividend,
    input  logic [mab_pkg::DIV_BITS-1:0]    divisor,
    output logic                            done,
    output logic [mab_pkg::SAMPLE_BITS-1:0] quotient
);
    import mab_pkg::*;

    logic [DIV_BITS-1:0]    rem_reg, rem_next;
    logic [SAMPLE_BITS-1:0] low_reg, low_next;
    logic [DIV_BITS-1:0]    dvs_reg, dvs_next;
    logic [STEP_BITS-1:0]   step_reg, step_next;
    logic                   done_reg, done_next;
    logic [DIV_BITS:0]      trial;
    logic                   fits;

    always_comb
    begin
        trial     = {rem_reg, low_reg[SAMPLE_BITS-1]};
        fits      = trial >= {1'b0, dvs_reg};
        rem_next  = rem_reg;
        low_next  = low_reg;
        dvs_next  = dvs_reg;
        step_next = step_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = dividend[ACC_BITS-1:SAMPLE_BITS];
            low_next  = dividend[SAMPLE_BITS-1:0];
            dvs_next  = divisor;
            step_next = STEP_BITS'(SAMPLE_BITS);
        end
        else if (step_reg != '0)
        begin
            rem_next  = fits ? DIV_BITS'(trial - {1'b0, dvs_reg}) : trial[DIV_BITS-1:0];
            low_next  = {low_reg[SAMPLE_BITS-2:0], fits};
            step_next = step_reg - STEP_BITS'(1);
            done_next = (step_reg == STEP_BITS'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        low_reg <= low_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = low_reg;

endmodule

// File: hw/rtl/moving_average_bank_core.sv
// Moving average bank top level: sequencer, history pointers and the multiply-accumulate.
// Depends on mab_pkg, mab_history and mab_divider.
//
// Input beats on s_*: s_tuser is the opcode (push or query), s_tdata carries the
// sample and the window length. A push keeps s_tready high and gives no output beat.
// A query walks the newest samples through the history memory read port, one per
// cycle, weighting and accumulating each, then divides in the restoring divider
// at one quotient bit per cycle. A query occupies the block until its result
// is registered for output; s_tready stays low meanwhile. Output beats on m_* carry the
// average and the short-history flag and sit in an output register, so the next
// item is accepted while a result waits; a finished query holds until that
// register is free. cfg_* writes the weight mode and is always ready.
// Reset clears the pointers, fill count, mode and handshake state; history slots
// not yet written since reset read as zero through the fill count, with no
// clearing pass.
module moving_average_bank_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // s_tdata: sample [23:0], window_length [32:24], zero pad
    input  logic [mab_pkg::S_TDATA_BITS-1:0]    s_tdata,
    // s_tuser: opcode [0]
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // m_tdata: average [23:0]
    output logic [mab_pkg::M_TDATA_BITS-1:0]    m_tdata,
    // m_tuser: short_history [0]
    output logic                                m_tuser,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [1:0]                          cfg_data
);
    import mab_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ACC  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_HOLD = 2'd3;

    logic [1:0]             state_reg, state_next;
    logic [1:0]             mode_reg, mode_next;
    logic [DEPTH_BITS-1:0]  wp_reg, wp_next;
    logic [COUNT_BITS-1:0]  seen_reg, seen_next;
    logic [COUNT_BITS-1:0]  n_reg, n_next;
    logic [COUNT_BITS-1:0]  cnt_reg, cnt_next;
    logic                   pend_reg, pend_next;
    logic [COUNT_BITS-1:0]  pend_j_reg, pend_j_next;
    logic [ACC_BITS-1:0]    acc_reg, acc_next;
    logic [DIV_BITS-1:0]    dvs_reg, dvs_next;
    logic                   short_reg, short_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [SAMPLE_BITS-1:0] avg_reg, avg_next;
    logic                   flag_reg, flag_next;

    logic                   in_beat;
    logic                   out_free;
    logic [COUNT_BITS-1:0]  win_raw;
    logic [COUNT_BITS-1:0]  win;
    logic [2*COUNT_BITS:0]  tri_prod;
    logic                   issue;
    logic [SAMPLE_BITS-1:0] rd_data;
    logic [SAMPLE_BITS-1:0] x;
    logic [COUNT_BITS-1:0]  weight;
    logic [SAMPLE_BITS+COUNT_BITS-1:0] prod;
    logic                   div_start;
    logic                   div_done;
    logic [SAMPLE_BITS-1:0] quotient;
    hist_req_t              req;

    mab_history u_history (
        .clk     (clk),
        .req     (req),
        .rd_data (rd_data)
    );

    mab_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (acc_reg),
        .divisor  (dvs_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_beat   = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign win_raw   = s_tdata[SAMPLE_BITS+COUNT_BITS-1:SAMPLE_BITS];
    assign issue     = (state_reg == ST_ACC) && (cnt_reg < n_reg);

    always_comb
    begin
        if (win_raw == '0)
        begin
            win = COUNT_BITS'(1);
        end
        else if (win_raw > COUNT_BITS'(HISTORY_DEPTH))
        begin
            win = COUNT_BITS'(HISTORY_DEPTH);
        end
        else
        begin
            win = win_raw;
        end
        tri_prod = (2*COUNT_BITS+1)'(win) * (2*COUNT_BITS+1)'({1'b0, win} + 1'b1);
    end

    always_comb
    begin
        x = (pend_j_reg < seen_reg) ? rd_data : '0;
        case (mode_reg)
            MODE_NEWEST: weight = n_reg - pend_j_reg;
            MODE_OLDEST: weight = pend_j_reg + COUNT_BITS'(1);
            default:     weight = COUNT_BITS'(1);
        endcase
        prod = (SAMPLE_BITS+COUNT_BITS)'(x) * (SAMPLE_BITS+COUNT_BITS)'(weight);
    end

    always_comb
    begin
        req.wr_en   = in_beat && (s_tuser == OP_PUSH);
        req.wr_addr = wp_reg;
        req.wr_data = s_tdata[SAMPLE_BITS-1:0];
        req.rd_en   = issue;
        req.rd_addr = wp_reg - DEPTH_BITS'(1) - cnt_reg[DEPTH_BITS-1:0];
    end

    always_comb
    begin
        state_next    = state_reg;
        mode_next     = (cfg_valid && cfg_ready) ? cfg_data : mode_reg;
        wp_next       = wp_reg;
        seen_next     = seen_reg;
        n_next        = n_reg;
        cnt_next      = cnt_reg;
        pend_next     = issue;
        pend_j_next   = cnt_reg;
        acc_next      = acc_reg;
        dvs_next      = dvs_reg;
        short_next    = short_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        avg_next      = avg_reg;
        flag_next     = flag_reg;
        div_start     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_beat && (s_tuser == OP_PUSH))
                begin
                    wp_next = wp_reg + DEPTH_BITS'(1);
                    if (seen_reg < COUNT_BITS'(HISTORY_DEPTH))
                    begin
                        seen_next = seen_reg + COUNT_BITS'(1);
                    end
                end
                else if (in_beat)
                begin
                    n_next     = win;
                    cnt_next   = '0;
                    acc_next   = '0;
                    short_next = seen_reg < win;
                    if ((mode_reg == MODE_NEWEST) || (mode_reg == MODE_OLDEST))
                    begin
                        dvs_next = tri_prod[DIV_BITS:1];
                    end
                    else
                    begin
                        dvs_next = DIV_BITS'(win);
                    end
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                if (issue)
                begin
                    cnt_next = cnt_reg + COUNT_BITS'(1);
                end
                if (pend_reg)
                begin
                    acc_next = acc_reg + ACC_BITS'(prod);
                end
                if (!issue && !pend_reg)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    if (out_free)
                    begin
                        m_tvalid_next = 1'b1;
                        avg_next      = quotient;
                        flag_next     = short_reg;
                        state_next    = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_HOLD;
                    end
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    avg_next      = quotient;
                    flag_next     = short_reg;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            mode_reg     <= MODE_MEAN;
            wp_reg       <= '0;
            seen_reg     <= '0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            mode_reg     <= mode_next;
            wp_reg       <= wp_next;
            seen_reg     <= seen_next;
            pend_reg     <= pend_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg      <= n_next;
        cnt_reg    <= cnt_next;
        pend_j_reg <= pend_j_next;
        acc_reg    <= acc_next;
        dvs_reg    <= dvs_next;
        short_reg  <= short_next;
        avg_reg    <= avg_next;
        flag_reg   <= flag_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_BITS'(avg_reg);
    assign m_tuser  = flag_reg;

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> (dvs_reg != '0))
        else $error("divider started with zero divisor");

    a_pend_in_acc: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (state_reg == ST_ACC))
        else $error("history read returned outside accumulation");

    a_seen_bound: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg <= COUNT_BITS'(HISTORY_DEPTH))
        else $error("fill count beyond history depth");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && !m_tready) |=> $stable(avg_reg))
        else $error("pending result overwritten");

endmodule
